FILE: rtl/substring_search_defines.svh
// ----------------------------------------------------------------------------
// Substring search assertion macros
// Shared concurrent assertion forms for the substring search RTL.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_SEARCH_DEFINES_SVH
`define SUBSTRING_SEARCH_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define SS_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("substring_search: same-cycle check failed");

// Consequent in the cycle after the antecedent.
`define SS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("substring_search: next-cycle check failed");

`endif

FILE: rtl/ss_pkg.sv
// ----------------------------------------------------------------------------
// Substring search package
// Shared widths, register indexes and cell control type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ss_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 64;
  localparam int LEN_W     = 5;
  localparam int REG_BYTES = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PAT_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

FILE: rtl/ss_cell.sv
// ----------------------------------------------------------------------------
// Substring search window cell
// Holds one window byte, passes it on to the next cell and compares the
// incoming byte with its pattern byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ss_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ss_pkg::cell_ctrl_t        ctrl_i,
  input  logic [ss_pkg::BYTE_W-1:0] data_i,
  input  logic [ss_pkg::BYTE_W-1:0] expect_i,
  input  logic                      active_i,
  output logic [ss_pkg::BYTE_W-1:0] data_o,
  output logic                      hit_o
);

  logic [ss_pkg::BYTE_W-1:0] data_q;

  // Compare against the byte that lands here on this transaction.
  assign hit_o  = !active_i || (data_i == expect_i);
  assign data_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (ctrl_i.shift) begin
      data_q <= ctrl_i.clear ? '0 : data_i;
    end
  end

endmodule

FILE: rtl/substring_search.sv
// ----------------------------------------------------------------------------
// Substring search
// Streaming first-occurrence search of a configured pattern in a byte text.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while the output is not stalled, with no
// gaps of its own: every cell of the window compares its byte with its
// pattern byte in parallel in the cycle the byte arrives. The result (found
// with the start offset, or not found at the last byte) appears in the
// output register in the cycle after the deciding byte is taken, and the next
// byte is taken in that same cycle unless the output is stalled. Pattern
// registers may be rewritten between texts; a write applies from the next
// byte. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "substring_search_defines.svh"

module substring_search #(
  parameter int MAX_PATTERN  = 16,
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ss_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ss_pkg::BYTE_W-1:0]    text_byte_i,
  input  logic                         last_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output logic [OFFSET_WIDTH-1:0]      match_offset_o
);

  localparam int CELLS = (MAX_PATTERN < ss_pkg::REG_BYTES) ? MAX_PATTERN : ss_pkg::REG_BYTES;
  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;

  logic [ss_pkg::CFG_W-1:0] pat_low_q, pat_high_q;
  logic [ss_pkg::LEN_W-1:0] pat_len_q;
  logic [2*ss_pkg::CFG_W-1:0] pat_flat;
  logic [ss_pkg::LEN_W-1:0] len_eff;

  logic [OFFSET_WIDTH-1:0] position_q, position_d;
  logic                    matched_q, matched_d;
  logic                    out_valid_q, out_valid_d;
  logic                    found_q, found_d;
  logic [OFFSET_WIDTH-1:0] offset_q, offset_d;

  logic                    in_acc;
  logic                    sat;
  logic                    have_ok;
  logic                    new_match;
  logic                    emit;
  logic [OFFSET_WIDTH-1:0] len_ext;
  logic [OFFSET_WIDTH-1:0] start_off;

  ss_pkg::cell_ctrl_t          cell_ctrl;
  logic [ss_pkg::BYTE_W-1:0]   cell_in  [CELLS];
  logic [ss_pkg::BYTE_W-1:0]   cell_out [CELLS];
  logic [CELLS-1:0]            cell_hit;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= ss_pkg::LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ss_pkg::CFG_PAT_LOW:  pat_low_q  <= cfg_data_i;
        ss_pkg::CFG_PAT_HIGH: pat_high_q <= cfg_data_i;
        ss_pkg::CFG_PAT_LEN:  pat_len_q  <= cfg_data_i[ss_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_flat = {pat_high_q, pat_low_q};

  // Clamp the length to 1..CELLS.
  always_comb begin
    len_eff = pat_len_q;
    if (pat_len_q == '0) begin
      len_eff = ss_pkg::LEN_W'(1);
    end else if (pat_len_q > ss_pkg::LEN_W'(CELLS)) begin
      len_eff = ss_pkg::LEN_W'(CELLS);
    end
  end

  assign in_acc          = in_valid_i && !in_stall_o;
  assign in_stall_o      = out_valid_q && out_stall_i;
  assign cell_ctrl.shift = in_acc;
  assign cell_ctrl.clear = last_byte_i;

  // Window chain: cell 0 takes the new byte, each cell feeds the next.
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    logic [ss_pkg::LEN_W-1:0] pidx;
    logic                     active;

    assign active = ss_pkg::LEN_W'(k) < len_eff;
    assign pidx   = len_eff - ss_pkg::LEN_W'(1) - ss_pkg::LEN_W'(k);

    if (k == 0) begin : g_head
      assign cell_in[k] = text_byte_i;
    end else begin : g_link
      assign cell_in[k] = cell_out[k-1];
    end

    ss_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .data_i   (cell_in[k]),
      .expect_i (pat_flat[pidx[ss_pkg::PAT_IDX_W-1:0]*ss_pkg::BYTE_W +: ss_pkg::BYTE_W]),
      .active_i (active),
      .data_o   (cell_out[k]),
      .hit_o    (cell_hit[k])
    );
  end

  assign len_ext   = {{(OFFSET_WIDTH-ss_pkg::LEN_W){1'b0}}, len_eff};
  assign sat       = (position_q == OFF_MAX);
  assign have_ok   = sat || (position_q >= (len_ext - OFFSET_WIDTH'(1)));
  assign new_match = !matched_q && have_ok && (&cell_hit);
  assign emit      = !matched_q && (new_match || last_byte_i);
  assign start_off = sat ? OFF_MAX : (position_q + OFFSET_WIDTH'(1) - len_ext);

  always_comb begin
    position_d  = position_q;
    matched_d   = matched_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    offset_d    = offset_q;
    // Drop the held result once it is taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      if (last_byte_i) begin
        position_d = '0;
        matched_d  = 1'b0;
      end else begin
        position_d = sat ? position_q : position_q + OFFSET_WIDTH'(1);
        matched_d  = matched_q || new_match;
      end
      if (emit) begin
        out_valid_d = 1'b1;
        found_d     = new_match;
        offset_d    = new_match ? start_off : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q  <= '0;
      matched_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      position_q  <= position_d;
      matched_q   <= matched_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q  <= found_d;
    offset_q <= offset_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;

  `SS_ASSERT_SAME(a_notfound_zero, clk_i, rst_ni, out_valid_o && !found_o, match_offset_o == '0)
  `SS_ASSERT_SAME(a_free_when_empty, clk_i, rst_ni, !out_valid_o, !in_stall_o)
  `SS_ASSERT_NEXT(a_silent_after_match, clk_i, rst_ni, in_acc && matched_q && !last_byte_i, !out_valid_o)
  `SS_ASSERT_NEXT(a_text_restart, clk_i, rst_ni, in_acc && last_byte_i, position_q == '0 && !matched_q)

endmodule
